[design/tspce_pkg.sv]
// Shared types, codes and constants for the one-wire temperature poll block.
// Holds the CRC-8 byte step used by the scratchpad reader. No dependencies.
`timescale 1ns / 1ps

package tspce_pkg;

  // Scratchpad length of the sensor, last byte is the CRC.
  localparam int SCRATCHPAD_BYTES_DEF = 9;

  // Field widths.
  localparam int NOW_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int TEMP_W  = 24;
  localparam int CFG_W   = 17;
  localparam int INDEX_W = 4;

  // Configuration register indexes.
  localparam logic CFG_CONV_TIME = 1'b0;
  localparam logic CFG_EMA_ALPHA = 1'b1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] CONV_TIME_RST = 17'd375;
  localparam logic [CFG_W-1:0] EMA_ALPHA_RST = 17'd6554;

  // Alpha of one in Q1.16.
  localparam logic [CFG_W-1:0] ALPHA_ONE = 17'd65536;

  // A raw reading at or below this value means a missing sensor.
  localparam logic signed [15:0] RAW_DISCONNECT_LIMIT = -16'sd2016;

  // Input beat kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Result actions.
  localparam logic [1:0] ACT_CONVERT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_REPORT  = 2'd2;

  // Reflected Dallas polynomial.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // One result beat.
  typedef struct packed {
    logic [1:0]               action;
    logic                     crc_error;
    logic                     valid_res;
    logic signed [TEMP_W-1:0] temperature;
  } result_t;

  // Dallas CRC-8 over one byte, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/tspce_ema.sv]
// Moving-average update of the filtered temperature, Q1.16 weight.
// Depends on tspce_pkg for widths and the alpha limit.
`timescale 1ns / 1ps

module tspce_ema (
  input  logic signed [tspce_pkg::TEMP_W-1:0] filtered,
  input  logic signed [tspce_pkg::TEMP_W-1:0] sample,
  input  logic        [tspce_pkg::CFG_W-1:0]  alpha,
  output logic signed [tspce_pkg::TEMP_W-1:0] updated
);

  logic signed [tspce_pkg::TEMP_W:0]       diff;
  logic        [tspce_pkg::CFG_W-1:0]      alpha_sat;
  logic signed [tspce_pkg::TEMP_W+18:0]    prod;
  logic signed [tspce_pkg::TEMP_W+18:0]    rounded;
  logic signed [tspce_pkg::TEMP_W+18:0]    step;

  // Weight saturates at one.
  assign alpha_sat = (alpha > tspce_pkg::ALPHA_ONE) ? tspce_pkg::ALPHA_ONE : alpha;

  // Difference to the new sample, one bit wider so it cannot wrap.
  assign diff = {sample[tspce_pkg::TEMP_W-1], sample}
              - {filtered[tspce_pkg::TEMP_W-1], filtered};

  assign prod = diff * $signed({1'b0, alpha_sat});

  // Round to nearest, ties upward: add half and take the floor.
  assign rounded = prod + 43'sd32768;
  assign step    = rounded >>> 16;

  // The step never leaves the span between old value and sample.
  assign updated = filtered + step[tspce_pkg::TEMP_W-1:0];

endmodule

[design/temp_sensor_poll_crc_ema.sv]
// Top level of the one-wire temperature poll with CRC-8 check and smoothing.
// Depends on tspce_pkg and tspce_ema.
`timescale 1ns / 1ps

// The block takes one beat per clock: a time tick or one scratchpad byte.
// A tick while idle asks for a conversion; a tick once conversion_time ticks
// have passed asks for a scratchpad read. The last scratchpad byte is checked
// against the CRC-8 of the ones before it and yields a report with the
// filtered temperature in 1/4096 degree units. Every beat is handled in the
// cycle it is accepted; its result goes to the output register, or to the
// skid entry while that is held. One beat per cycle is taken unless the input
// stalls; the path that sets the clock is the filter update (subtract, one
// 25x18 multiply, round, add). Results wait in an output register backed by
// one skid entry, so input beats keep flowing while one result is held by the
// sink; the input stalls only while a second result waits in the skid entry.

module temp_sensor_poll_crc_ema #(
  parameter int SCRATCHPAD_BYTES = tspce_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input beats. tdata: now [31:0], data_byte [39:32]. tuser: command.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  // Result beats. tdata: temperature [23:0], valid_res [24], crc_error [25].
  // tuser: action.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tspce_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [tspce_pkg::INDEX_W-1:0] LAST_INDEX =
    tspce_pkg::INDEX_W'(SCRATCHPAD_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CONVERT,
    PH_READ
  } phase_t;

  // Configuration registers.
  logic [tspce_pkg::CFG_W-1:0] conversion_time;
  logic [tspce_pkg::CFG_W-1:0] ema_alpha;

  // Poll state.
  phase_t                                 phase, phase_next;
  logic [tspce_pkg::NOW_W-1:0]            convert_start_time, convert_start_time_next;
  logic [tspce_pkg::INDEX_W-1:0]          byte_index, byte_index_next;
  logic [7:0]                             crc_accumulator, crc_accumulator_next;
  logic [7:0]                             temp_low_byte, temp_low_byte_next;
  logic [7:0]                             temp_high_byte, temp_high_byte_next;
  logic signed [tspce_pkg::TEMP_W-1:0]    filtered_temp, filtered_temp_next;
  logic                                   reading_valid, reading_valid_next;

  // Output register and skid entry.
  tspce_pkg::result_t out_reg, skid_reg, res;
  logic               skid_valid;
  logic               res_valid;

  logic                                   accept;
  logic                                   command;
  logic [tspce_pkg::NOW_W-1:0]            now;
  logic [7:0]                             data_byte;
  logic [tspce_pkg::NOW_W-1:0]            elapsed;
  logic signed [15:0]                     raw;
  logic signed [tspce_pkg::TEMP_W-1:0]    sample;
  logic signed [tspce_pkg::TEMP_W-1:0]    ema_value;
  logic                                   crc_bad;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign command   = s_axis_tuser;
  assign now       = s_axis_tdata[31:0];
  assign data_byte = s_axis_tdata[39:32];

  assign elapsed = now - convert_start_time;
  assign raw     = $signed({temp_high_byte, temp_low_byte});
  assign sample  = {raw, 8'h00};
  assign crc_bad = (data_byte != crc_accumulator);

  // Filter update for the good-sample case.
  tspce_ema u_ema (
    .filtered (filtered_temp),
    .sample   (sample),
    .alpha    (ema_alpha),
    .updated  (ema_value)
  );

  // Next state and result of the accepted beat.
  always_comb begin
    phase_next              = phase;
    convert_start_time_next = convert_start_time;
    byte_index_next         = byte_index;
    crc_accumulator_next    = crc_accumulator;
    temp_low_byte_next      = temp_low_byte;
    temp_high_byte_next     = temp_high_byte;
    filtered_temp_next      = filtered_temp;
    reading_valid_next      = reading_valid;
    res_valid               = 1'b0;
    res.action              = tspce_pkg::ACT_CONVERT;
    res.crc_error           = 1'b0;

    if (accept) begin
      unique case (phase)
        PH_IDLE: begin
          if (command == tspce_pkg::CMD_TICK) begin
            convert_start_time_next = now;
            phase_next              = PH_CONVERT;
            res_valid               = 1'b1;
            res.action              = tspce_pkg::ACT_CONVERT;
          end
        end
        PH_CONVERT: begin
          if (command == tspce_pkg::CMD_TICK &&
              elapsed >= {{(tspce_pkg::NOW_W - tspce_pkg::CFG_W){1'b0}}, conversion_time}) begin
            phase_next           = PH_READ;
            byte_index_next      = '0;
            crc_accumulator_next = '0;
            res_valid            = 1'b1;
            res.action           = tspce_pkg::ACT_READ;
          end
        end
        PH_READ: begin
          if (command == tspce_pkg::CMD_BYTE) begin
            if (byte_index >= LAST_INDEX) begin
              // Check byte: close the reading and report.
              phase_next      = PH_IDLE;
              byte_index_next = '0;
              res_valid       = 1'b1;
              res.action      = tspce_pkg::ACT_REPORT;
              res.crc_error   = crc_bad;
              if (crc_bad || raw <= tspce_pkg::RAW_DISCONNECT_LIMIT) begin
                reading_valid_next = 1'b0;
              end else begin
                filtered_temp_next = reading_valid ? ema_value : sample;
                reading_valid_next = 1'b1;
              end
            end else begin
              if (byte_index == '0) begin
                temp_low_byte_next = data_byte;
              end
              if (byte_index == tspce_pkg::INDEX_W'(1)) begin
                temp_high_byte_next = data_byte;
              end
              crc_accumulator_next = tspce_pkg::crc8_byte(crc_accumulator, data_byte);
              byte_index_next      = byte_index + 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.temperature = filtered_temp_next;
    res.valid_res   = reading_valid_next;
  end

  // Poll state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      convert_start_time <= '0;
      byte_index         <= '0;
      crc_accumulator    <= '0;
      temp_low_byte      <= '0;
      temp_high_byte     <= '0;
      filtered_temp      <= '0;
      reading_valid      <= 1'b0;
      conversion_time    <= tspce_pkg::CONV_TIME_RST;
      ema_alpha          <= tspce_pkg::EMA_ALPHA_RST;
    end else begin
      phase              <= phase_next;
      convert_start_time <= convert_start_time_next;
      byte_index         <= byte_index_next;
      crc_accumulator    <= crc_accumulator_next;
      temp_low_byte      <= temp_low_byte_next;
      temp_high_byte     <= temp_high_byte_next;
      filtered_temp      <= filtered_temp_next;
      reading_valid      <= reading_valid_next;
      if (cfg_we) begin
        unique case (cfg_index)
          tspce_pkg::CFG_CONV_TIME: conversion_time <= cfg_data;
          tspce_pkg::CFG_EMA_ALPHA: ema_alpha       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Output register with one skid entry. Input stalls only when both are full.
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        out_reg       <= skid_reg;
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        out_reg       <= res;
        m_axis_tvalid <= res_valid;
      end
    end else if (res_valid) begin
      skid_reg   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tdata = {6'b0, out_reg.crc_error, out_reg.valid_res, out_reg.temperature};
  assign m_axis_tuser = out_reg.action;

endmodule

[sim/temp_poll_checker.sv]
// Scoreboard for the one-wire temperature poll block: watches the input, result and
// register-write channels, predicts every result beat and compares it field by field.
// Depends on tspce_pkg for widths, beat kinds, actions and register indexes.
`timescale 1ns / 1ps

module temp_poll_checker
  import tspce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // tdata: now [31:0], data_byte [39:32]. tuser: command.
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  // tdata: temperature [23:0], valid_res [24], crc_error [25]. tuser: action.
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [31:0]          m_axis_tdata,
  input  logic [1:0]           m_axis_tuser,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_checked,
  output int                   reports_seen,
  output int                   crc_failures
);

  localparam int PAD_BYTES = SCRATCHPAD_BYTES_DEF;

  typedef enum logic [1:0] {POLL_IDLE, POLL_CONVERTING, POLL_READING} poll_phase_t;

  typedef struct {
    logic [1:0]               action;
    logic signed [TEMP_W-1:0] temperature;
    logic                     valid_res;
    logic                     crc_error;
  } poll_result_t;

  // Mirror of the block's registers and poll state.
  logic [CFG_W-1:0]         conv_ticks;
  logic [CFG_W-1:0]         alpha;
  poll_phase_t              phase;
  logic [NOW_W-1:0]         conv_started;
  int                       pad_index;
  logic [7:0]               crc_acc;
  logic [7:0]               raw_lo;
  logic [7:0]               raw_hi;
  logic signed [TEMP_W-1:0] filtered;
  logic                     have_reading;

  poll_result_t awaited_results[$];
  int err_total;
  int checked_total;
  int report_total;
  int crc_bad_total;

  // Dallas CRC-8, shifted in one bit at a time, LSB first.
  function automatic logic [7:0] dallas_crc(input logic [7:0] acc, input logic [7:0] din);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ din[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ 8'h8C;
      end
    end
    return acc;
  endfunction

  // Moving average step: old + round(alpha * (sample - old) / 2^16), ties upward.
  function automatic logic signed [TEMP_W-1:0] ema_update(
    input logic signed [TEMP_W-1:0] old,
    input logic signed [TEMP_W-1:0] sample,
    input logic [CFG_W-1:0]         weight
  );
    longint w;
    longint prod;
    longint sum;
    w = weight;
    if (w > longint'(ALPHA_ONE)) begin
      w = longint'(ALPHA_ONE);
    end
    prod = (longint'(sample) - longint'(old)) * w + 64'sd32768;
    sum  = longint'(old) + (prod >>> 16);
    return sum[TEMP_W-1:0];
  endfunction

  task automatic note_result(input logic [1:0] act, input logic crc_err);
    poll_result_t r;
    r.action      = act;
    r.temperature = filtered;
    r.valid_res   = have_reading;
    r.crc_error   = crc_err;
    awaited_results.push_back(r);
  endtask

  // Advance the poll state by one accepted input beat.
  task automatic advance_poll(input logic cmd, input logic [NOW_W-1:0] now,
                              input logic [7:0] din);
    logic signed [15:0] raw;
    logic               bad;
    if (cmd == CMD_TICK) begin
      case (phase)
        POLL_IDLE: begin
          conv_started = now;
          phase = POLL_CONVERTING;
          note_result(ACT_CONVERT, 1'b0);
        end
        POLL_CONVERTING: begin
          if (NOW_W'(now - conv_started) >= NOW_W'(conv_ticks)) begin
            phase = POLL_READING;
            pad_index = 0;
            crc_acc = 8'h00;
            note_result(ACT_READ, 1'b0);
          end
        end
        default: begin
          // Ticks are ignored while the scratchpad is being read.
        end
      endcase
    end else if (phase == POLL_READING) begin
      if (pad_index >= PAD_BYTES - 1) begin
        // Last byte carries the CRC of all bytes before it.
        bad = (din != crc_acc);
        raw = {raw_hi, raw_lo};
        phase = POLL_IDLE;
        pad_index = 0;
        if (bad || raw <= RAW_DISCONNECT_LIMIT) begin
          have_reading = 1'b0;
        end else if (have_reading) begin
          filtered = ema_update(filtered, {raw, 8'h00}, alpha);
        end else begin
          filtered = {raw, 8'h00};
          have_reading = 1'b1;
        end
        note_result(ACT_REPORT, bad);
      end else begin
        if (pad_index == 0) begin
          raw_lo = din;
        end else if (pad_index == 1) begin
          raw_hi = din;
        end
        crc_acc = dallas_crc(crc_acc, din);
        pad_index++;
      end
    end
  endtask

  // Compare result beats first: a beat leaving this cycle was caused earlier.
  always @(posedge clk) begin : watch_beats
    poll_result_t want;
    poll_result_t got;
    if (rst) begin
      conv_ticks    = CONV_TIME_RST;
      alpha         = EMA_ALPHA_RST;
      phase         = POLL_IDLE;
      conv_started  = '0;
      pad_index     = 0;
      crc_acc       = 8'h00;
      raw_lo        = 8'h00;
      raw_hi        = 8'h00;
      filtered      = '0;
      have_reading  = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.action      = m_axis_tuser;
        got.temperature = m_axis_tdata[TEMP_W-1:0];
        got.valid_res   = m_axis_tdata[TEMP_W];
        got.crc_error   = m_axis_tdata[TEMP_W+1];
        checked_total++;
        if (got.action == ACT_REPORT) begin
          report_total++;
        end
        if (got.crc_error) begin
          crc_bad_total++;
        end
        if (awaited_results.size() == 0) begin
          $error("unexpected result beat: action %0d, temperature %0d",
                 got.action, got.temperature);
          err_total++;
        end else begin
          want = awaited_results.pop_front();
          if (got.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got.action);
            err_total++;
          end
          if (got.temperature !== want.temperature) begin
            $error("temperature: expected %0d, actual %0d",
                   want.temperature, got.temperature);
            err_total++;
          end
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", want.valid_res, got.valid_res);
            err_total++;
          end
          if (got.crc_error !== want.crc_error) begin
            $error("crc_error: expected %0d, actual %0d", want.crc_error, got.crc_error);
            err_total++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_poll(s_axis_tuser, s_axis_tdata[NOW_W-1:0], s_axis_tdata[NOW_W+7:NOW_W]);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_CONV_TIME) begin
          conv_ticks = cfg_data;
        end else begin
          alpha = cfg_data;
        end
      end
    end
    mismatches      <= err_total;
    outstanding     <= awaited_results.size();
    results_checked <= checked_total;
    reports_seen    <= report_total;
    crc_failures    <= crc_bad_total;
  end

  initial begin
    err_total     = 0;
    checked_total = 0;
    report_total  = 0;
    crc_bad_total = 0;
  end

endmodule

[sim/testbench.sv]
// Top of the temperature poll testbench: clock, reset, register writes and beat traffic.
// Instantiates temp_sensor_poll_crc_ema and temp_poll_checker; uses tspce_pkg.
`timescale 1ns / 1ps

module testbench;
  import tspce_pkg::*;

  localparam int PAD_BYTES     = SCRATCHPAD_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STRAY_PCT     = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int results_checked;
  int reports_seen;
  int crc_failures;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int beats_sent      = 0;
  int cycle_count     = 0;
  logic [CFG_W-1:0] conv_ticks;

  always #1 clk = ~clk;

  temp_sensor_poll_crc_ema uut (.*);

  temp_poll_checker chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .outstanding(pending), .results_checked, .reports_seen, .crc_failures
  );

  // Sink stalls at random.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL temp_sensor_poll_crc_ema");
      $finish;
    end
  end

  // Present one beat, idling first at random, and hold it until accepted.
  task automatic send_beat(input logic cmd, input logic [NOW_W-1:0] now,
                           input logic [7:0] din, input bit counted);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {din, now};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    if (counted) begin
      beats_sent++;
    end
  endtask

  // Scratchpad with the given raw temperature; a nonzero flip spoils the CRC byte.
  task automatic send_scratchpad(input logic [15:0] raw, input logic [7:0] flip,
                                 input int stray_pct);
    logic [7:0] pad [PAD_BYTES];
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < PAD_BYTES - 1; i++) begin
      if (i == 0) begin
        pad[i] = raw[7:0];
      end else if (i == 1) begin
        pad[i] = raw[15:8];
      end else begin
        pad[i] = 8'($urandom);
      end
      crc = crc8_byte(crc, pad[i]);
    end
    pad[PAD_BYTES-1] = crc ^ flip;
    for (int i = 0; i < PAD_BYTES; i++) begin
      if ($urandom_range(99) < stray_pct) begin
        send_beat(CMD_TICK, $urandom, 8'($urandom), 1'b0);
      end
      send_beat(CMD_BYTE, $urandom, pad[i], 1'b1);
    end
  endtask

  // One full poll: convert request, early ticks, read request, scratchpad.
  task automatic poll_once(input int stray_pct);
    logic [NOW_W-1:0] t0;
    logic [NOW_W-1:0] extra;
    logic [15:0]      raw;
    logic [7:0]       flip;
    int               pick;
    if ($urandom_range(99) < 2 * stray_pct) begin
      send_beat(CMD_BYTE, $urandom, 8'($urandom), 1'b0);
    end
    if ($urandom_range(99) < 20) begin
      t0 = 32'hFFFF_FFFF - $urandom_range(0, 64);
    end else begin
      t0 = $urandom;
    end
    send_beat(CMD_TICK, t0, 8'($urandom), 1'b1);
    if (conv_ticks != '0) begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(99) < stray_pct) begin
          send_beat(CMD_BYTE, $urandom, 8'($urandom), 1'b0);
        end
        send_beat(CMD_TICK, t0 + $urandom_range(0, conv_ticks - 1), 8'($urandom), 1'b1);
      end
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      extra = '0;
    end else if (pick < 80) begin
      extra = $urandom_range(0, 50);
    end else begin
      extra = $urandom_range(0, 32'hFFFF_FFFF - conv_ticks);
    end
    send_beat(CMD_TICK, t0 + conv_ticks + extra, 8'($urandom), 1'b1);
    // Mostly plausible temperatures, some extremes and the disconnect boundary.
    pick = $urandom_range(99);
    if (pick < 60) begin
      raw = 16'($urandom_range(0, 2880) - 880);
    end else if (pick < 70) begin
      raw = 16'($urandom);
    end else if (pick < 75) begin
      raw = 16'hF820;
    end else if (pick < 80) begin
      raw = 16'hF821;
    end else if (pick < 85) begin
      raw = 16'h7FFF;
    end else if (pick < 90) begin
      raw = 16'h8000;
    end else begin
      raw = 16'($urandom_range(0, 16) - 8);
    end
    flip = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_scratchpad(raw, flip, stray_pct);
  endtask

  // Register writes only once the input is idle and every result has drained.
  task automatic reconfigure(input logic [CFG_W-1:0] ticks, input logic [CFG_W-1:0] weight);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONV_TIME;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_index <= CFG_EMA_ALPHA;
    cfg_data  <= weight;
    @(posedge clk);
    cfg_we <= 1'b0;
    conv_ticks = ticks;
  endtask

  task automatic run_polls(input int idle_pct, input int stall_pct, input int target);
    int first;
    first = beats_sent;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    while (beats_sent - first < target) begin
      poll_once(STRAY_PCT);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    m_axis_tready <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_CONV_TIME;
    cfg_data      <= '0;
    conv_ticks = CONV_TIME_RST;
    sender_idle_pct = 34;
    sink_stall_pct  = 71;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: shortest wait, no smoothing, wrap of the time counter,
    // ignored beats, hottest reading and the disconnect boundary.
    reconfigure(17'd1, ALPHA_ONE);
    send_beat(CMD_BYTE, $urandom, 8'hFF, 1'b0);
    send_beat(CMD_TICK, 32'hFFFF_FFFF, 8'h00, 1'b1);
    send_beat(CMD_BYTE, 32'h0000_0000, 8'h00, 1'b0);
    send_beat(CMD_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_beat(CMD_TICK, 32'h0000_0000, 8'h00, 1'b1);
    send_beat(CMD_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_scratchpad(16'h7FFF, 8'h00, 0);
    send_beat(CMD_TICK, 32'h0000_0000, 8'h00, 1'b1);
    send_beat(CMD_TICK, 32'h8000_0000, 8'hFF, 1'b1);
    send_scratchpad(16'hF820, 8'h00, 0);

    // Random polls over several register settings and idling mixes.
    reconfigure(CONV_TIME_RST, EMA_ALPHA_RST);
    run_polls(34, 71, 140);
    reconfigure(17'd100000, 17'd0);
    run_polls(71, 34, 140);
    reconfigure(17'd0, 17'h1FFFF);
    run_polls(0, 0, 85);
    reconfigure(17'($urandom_range(1, 131071)), 17'd32768);
    run_polls(0, 0, 85);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    $display("Sent %0d poll beats over five register settings and three idling mixes.",
             beats_sent);
    $display("Checked %0d result beats: %0d reading reports, %0d with a bad CRC.",
             results_checked, reports_seen, crc_failures);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS temp_sensor_poll_crc_ema");
    end else begin
      $display("FAIL temp_sensor_poll_crc_ema");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tspce_pkg.sv
design/tspce_ema.sv
design/temp_sensor_poll_crc_ema.sv
sim/temp_poll_checker.sv
sim/testbench.sv
